// File: hdl/sbus_frame_decoder_defines.svh
// ----------------------------------------------------------------------------
// sbus_frame_decoder_defines: assertion macros
// Concurrent checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SBUS_FRAME_DECODER_DEFINES_SVH
`define SBUS_FRAME_DECODER_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define SBFD_ASSERT_IMPL(name, clock, rst_n, ante, cons) \
	name: assert property (@(posedge clock) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sbfd assertion failed");
// next-cycle implication
`define SBFD_ASSERT_NEXT(name, clock, rst_n, ante, cons) \
	name: assert property (@(posedge clock) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sbfd assertion failed");
`else
`define SBFD_ASSERT_IMPL(name, clock, rst_n, ante, cons)
`define SBFD_ASSERT_NEXT(name, clock, rst_n, ante, cons)
`endif

`endif

// File: hdl/sbfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbfd_pkg: shared types and constants
// Frame layout, field widths, register indexes and reset values.
// ----------------------------------------------------------------------------
package sbfd_pkg;

	localparam int FRAME_BYTES  = 25;
	localparam int NUM_CHANNELS = 16;
	localparam int CHANNEL_BITS = 11;
	localparam int BYTE_W       = 8;
	localparam int CH_W         = 4;
	localparam int VALUE_W      = 12;
	localparam int CLASS_W      = 2;
	localparam int IDX_W        = $clog2(FRAME_BYTES);
	localparam int IDLE_W       = 8;
	localparam int UPTIME_W     = 16;
	localparam int THRESH_W     = 12;
	// bytes 0 .. FRAME_BYTES-2 are held; the footer is checked on arrival
	localparam int SHIFT_W      = (FRAME_BYTES - 1) * BYTE_W;
	localparam int FLAG_LSB     = (FRAME_BYTES - 2) * BYTE_W;

	localparam logic [BYTE_W-1:0]  HEADER_BYTE  = 8'h0F;
	localparam logic [BYTE_W-1:0]  FOOTER_BYTE  = 8'h00;
	localparam logic [VALUE_W-1:0] VALUE_OFFSET = 12'd880;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_GAP_LIMIT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STARTUP   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SW_LOW    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SW_HIGH   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FAILSAFE  = 3'd4;

	localparam logic [IDLE_W-1:0]   GAP_LIMIT_RST = 8'd3;
	localparam logic [UPTIME_W-1:0] STARTUP_RST   = 16'd2000;
	localparam logic [THRESH_W-1:0] SW_LOW_RST    = 12'd1000;
	localparam logic [THRESH_W-1:0] SW_HIGH_RST   = 12'd1600;
	localparam logic [BYTE_W-1:0]   FAILSAFE_RST  = 8'd12;

	typedef enum logic {
		CMD_TICK = 1'b0,
		CMD_BYTE = 1'b1
	} cmd_t;

	typedef enum logic [CLASS_W-1:0] {
		CLS_LOW  = 2'd0,
		CLS_MID  = 2'd1,
		CLS_HIGH = 2'd2
	} sw_class_t;

	typedef enum logic [1:0] {
		S_RECV = 2'b01,
		S_EMIT = 2'b10
	} state_t;

endpackage

// File: hdl/sbfd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbfd_if: stream channels of the frame decoder
// Input items (ticks and bytes) and decoded channel results, valid/ready.
// ----------------------------------------------------------------------------
interface sbfd_in_if import sbfd_pkg::*; ();
	logic              valid;
	logic              ready;
	cmd_t              command;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output command, output rx_byte, input ready);
	modport sink   (input valid, input command, input rx_byte, output ready);
endinterface

interface sbfd_out_if import sbfd_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [CH_W-1:0]    channel;
	logic [VALUE_W-1:0] value;
	sw_class_t          switch_class;
	logic [BYTE_W-1:0]  flag_byte;
	logic               failsafe;
	logic               last;

	modport source (output valid, output channel, output value, output switch_class,
		output flag_byte, output failsafe, output last, input ready);
	modport sink   (input valid, input channel, input value, input switch_class,
		input flag_byte, input failsafe, input last, output ready);
endinterface

// File: hdl/sbus_frame_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbus_frame_decoder: serial bus receiver frame decoder
// Gathers 25-byte frames from ticks and bytes, checks header and footer and
// shifts out sixteen 11-bit channels, scaled and classified, one per cycle while the servo sink is ready.
//
//   port    | dir  | carries
//   --------+------+---------------------------------------------
//   rx      | sink | command (tick/byte), rx_byte
//   servo   | src  | channel, value, switch_class, flag_byte,
//           |      | failsafe, last
//   cfg_*   | in   | register writes, index 0..4
//
// Ticks and bytes are taken only while no burst is running. The footer byte
// of a good frame starts a burst: the frame shift register moves one 11-bit
// channel per cycle into the output register, and rx is held off until the
// burst ends. A stalled servo sink freezes the burst. Reset restores register
// defaults and counters at once; the frame store needs no clearing.
// ----------------------------------------------------------------------------
`include "sbus_frame_decoder_defines.svh"

module sbus_frame_decoder import sbfd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	sbfd_in_if.sink               rx,
	sbfd_out_if.source            servo
);

	// configuration
	logic [IDLE_W-1:0]   gap_q;
	logic [UPTIME_W-1:0] startup_q;
	logic [THRESH_W-1:0] sw_lo_q;
	logic [THRESH_W-1:0] sw_hi_q;
	logic [BYTE_W-1:0]   fsv_q;

	// control
	state_t              state_q;
	logic [IDX_W-1:0]    byte_idx_q;
	logic [IDLE_W-1:0]   idle_q;
	logic [UPTIME_W-1:0] uptime_q;
	logic [CH_W-1:0]     ch_q;
	logic                out_valid_q;

	// payload
	logic [SHIFT_W-1:0]  sh_q;
	logic [BYTE_W-1:0]   flag_q;
	logic                fs_q;
	logic [CH_W-1:0]     out_ch_q;
	logic [VALUE_W-1:0]  out_value_q;
	sw_class_t           out_cls_q;
	logic [BYTE_W-1:0]   out_flag_q;
	logic                out_fs_q;
	logic                out_last_q;

	logic                in_fire;
	logic                tick_fire;
	logic                store;
	logic [IDX_W-1:0]    idx_c;
	logic                frame_end;
	logic                frame_good;
	logic                out_load;
	logic [CHANNEL_BITS-1:0] raw;
	logic [CHANNEL_BITS+2:0] times5;
	logic [VALUE_W-1:0]  value_c;
	sw_class_t           cls_c;

	assign rx.ready  = (state_q == S_RECV);
	assign in_fire   = rx.valid && rx.ready;
	assign tick_fire = in_fire && (rx.command == CMD_TICK);
	// drop bytes until the startup time has passed
	assign store     = in_fire && (rx.command == CMD_BYTE) && (uptime_q >= startup_q);
	assign idx_c     = (idle_q > gap_q) ? '0 : byte_idx_q;
	assign frame_end = store && (idx_c == IDX_W'(FRAME_BYTES - 1));
	// byte 0 has reached the bottom of the shift register by the footer
	assign frame_good = frame_end && (sh_q[BYTE_W-1:0] == HEADER_BYTE)
		&& (rx.rx_byte == FOOTER_BYTE);
	assign out_load  = (state_q == S_EMIT) && (!out_valid_q || servo.ready);

	// channel digit sits just above the header byte slot
	always_comb begin
		raw     = sh_q[BYTE_W +: CHANNEL_BITS];
		times5  = {1'b0, raw, 2'b00} + {3'b000, raw};
		value_c = {1'b0, times5[CHANNEL_BITS+2:3]} + VALUE_OFFSET;
		if (value_c > sw_lo_q) begin
			cls_c = (value_c < sw_hi_q) ? CLS_MID : CLS_HIGH;
		end else begin
			cls_c = CLS_LOW;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q     <= GAP_LIMIT_RST;
			startup_q <= STARTUP_RST;
			sw_lo_q   <= SW_LOW_RST;
			sw_hi_q   <= SW_HIGH_RST;
			fsv_q     <= FAILSAFE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GAP_LIMIT: gap_q     <= cfg_wdata[IDLE_W-1:0];
				REG_STARTUP:   startup_q <= cfg_wdata[UPTIME_W-1:0];
				REG_SW_LOW:    sw_lo_q   <= cfg_wdata[THRESH_W-1:0];
				REG_SW_HIGH:   sw_hi_q   <= cfg_wdata[THRESH_W-1:0];
				REG_FAILSAFE:  fsv_q     <= cfg_wdata[BYTE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_RECV;
			byte_idx_q  <= '0;
			idle_q      <= '1;
			uptime_q    <= '0;
			ch_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (tick_fire) begin
				if (uptime_q != '1) begin
					uptime_q <= uptime_q + 1'b1;
				end
				if (idle_q != '1) begin
					idle_q <= idle_q + 1'b1;
				end
			end
			if (store) begin
				idle_q     <= '0;
				byte_idx_q <= frame_end ? '0 : idx_c + 1'b1;
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (servo.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_RECV: begin
					if (frame_good) begin
						state_q <= S_EMIT;
						ch_q    <= '0;
					end
				end
				S_EMIT: begin
					if (out_load) begin
						ch_q <= ch_q + 1'b1;
						if (ch_q == CH_W'(NUM_CHANNELS - 1)) begin
							state_q <= S_RECV;
						end
					end
				end
				default: begin
					state_q <= S_RECV;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		// the footer itself is not shifted in, which keeps the payload in place
		if (store && !frame_end) begin
			sh_q <= {rx.rx_byte, sh_q[SHIFT_W-1:BYTE_W]};
		end else if (out_load) begin
			sh_q <= {{CHANNEL_BITS{1'b0}}, sh_q[SHIFT_W-1:CHANNEL_BITS]};
		end
		if (frame_good) begin
			flag_q <= sh_q[FLAG_LSB +: BYTE_W];
			fs_q   <= (sh_q[FLAG_LSB +: BYTE_W] == fsv_q);
		end
		// flag travels with each channel so a held result keeps its own frame's flag
		if (out_load) begin
			out_ch_q    <= ch_q;
			out_value_q <= value_c;
			out_cls_q   <= cls_c;
			out_flag_q  <= flag_q;
			out_fs_q    <= fs_q;
			out_last_q  <= (ch_q == CH_W'(NUM_CHANNELS - 1));
		end
	end

	assign servo.valid        = out_valid_q;
	assign servo.channel      = out_ch_q;
	assign servo.value        = out_value_q;
	assign servo.switch_class = out_cls_q;
	assign servo.flag_byte    = out_flag_q;
	assign servo.failsafe     = out_fs_q;
	assign servo.last         = out_last_q;

	`SBFD_ASSERT_NEXT(a_good_frame_starts_burst, clk, arst_n, frame_good, (state_q == S_EMIT) && (ch_q == '0))
	`SBFD_ASSERT_IMPL(a_byte_index_in_frame, clk, arst_n, 1'b1, byte_idx_q < IDX_W'(FRAME_BYTES))
	`SBFD_ASSERT_NEXT(a_stored_byte_clears_idle, clk, arst_n, store, (idle_q == '0) && (state_q == S_EMIT || byte_idx_q != '0 || $past(frame_end)))

endmodule
